/* hw/rtl/mic_pkg.sv */
package mic_pkg;

  localparam int SampleW = 16;
  localparam int CfgW    = 16;
  localparam int CfgIdxW = 3;

  // Register map of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_BIAS_X       = 3'd0,
    CFG_BIAS_Y       = 3'd1,
    CFG_BIAS_Z       = 3'd2,
    CFG_INV_GAIN_X   = 3'd3,
    CFG_INV_GAIN_Y   = 3'd4,
    CFG_INV_GAIN_Z   = 3'd5,
    CFG_COMMON_SCALE = 3'd6
  } cfg_reg_t;

  localparam logic [CfgW-1:0] GainReset = 16'd16384;

  // Working set of the digit-by-digit square root.
  typedef struct packed {
    logic [17:0] rem;
    logic [15:0] root;
    logic [31:0] rad;
  } root_state_t;

  // Everything that travels through one square root stage.
  typedef struct packed {
    logic [2:0][SampleW-1:0] cal;
    logic                    ovf;
    logic                    big;
    root_state_t             rt;
  } root_stage_t;

endpackage

/* hw/rtl/mic_if.sv */
interface mic_sample_if;
  import mic_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] raw_x;
  logic signed [SampleW-1:0] raw_y;
  logic signed [SampleW-1:0] raw_z;

  modport source (output valid, output raw_x, output raw_y, output raw_z, input ready);
  modport sink   (input valid, input raw_x, input raw_y, input raw_z, output ready);
endinterface

interface mic_result_if;
  import mic_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] cal_x;
  logic signed [SampleW-1:0] cal_y;
  logic signed [SampleW-1:0] cal_z;
  logic        [SampleW-1:0] magnitude;
  logic                      overflow;

  modport source (output valid, output cal_x, output cal_y, output cal_z,
                  output magnitude, output overflow, input ready);
  modport sink   (input valid, input cal_x, input cal_y, input cal_z,
                  input magnitude, input overflow, output ready);
endinterface

/* hw/rtl/magnetometer_iron_calibration.sv */
// Channel   Direction  Transfer when          Payload
// sample    in         valid && ready         raw_x, raw_y, raw_z (signed 16 bit)
// result    out        valid && ready         cal_x, cal_y, cal_z, magnitude, overflow
// cfg       in         cfg_we high            cfg_idx (3 bit), cfg_data (16 bit)
//
// One sample is taken per cycle while the result side accepts; each one passes
// through the two multiplier stages, the squaring and summing stages and
// the eight stages of the square root, each of which resolves two result bits.
// Reset is synchronous and clears the stage valid bits and the configuration
// registers to their defaults. Every stage holds its item while the next one is full and
// stalled, and an empty stage always fills, so bubbles are squeezed out.
module magnetometer_iron_calibration (
  input  logic                         clk,
  input  logic                         rst,
  mic_sample_if.sink                   sample,
  mic_result_if.source                 result,
  input  logic                         cfg_we,
  input  logic [mic_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [mic_pkg::CfgW-1:0]     cfg_data
);
  import mic_pkg::*;

  localparam int RootStages = 8;
  localparam int NumStages  = 4 + RootStages;

  // Configuration registers: bias and inverse gain with one lane per axis, and a shared common scale.
  logic signed [SampleW-1:0] bias     [3];
  logic        [CfgW-1:0]    inv_gain [3];
  logic        [CfgW-1:0]    common_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        bias[a]     <= '0;
        inv_gain[a] <= GainReset;
      end
      common_scale <= GainReset;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        CFG_BIAS_X:       bias[0]      <= cfg_data;
        CFG_BIAS_Y:       bias[1]      <= cfg_data;
        CFG_BIAS_Z:       bias[2]      <= cfg_data;
        CFG_INV_GAIN_X:   inv_gain[0]  <= cfg_data;
        CFG_INV_GAIN_Y:   inv_gain[1]  <= cfg_data;
        CFG_INV_GAIN_Z:   inv_gain[2]  <= cfg_data;
        CFG_COMMON_SCALE: common_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // Flow control. A stage loads when it is empty or when its item moves on;
  // en[NumStages+1] is the downstream ready.
  logic [NumStages:1]   vld;
  logic [NumStages+1:1] en;

  assign en[NumStages+1] = result.ready;
  for (genvar i = 1; i <= NumStages; i++) begin : g_en
    assign en[i] = !vld[i] || en[i+1];
  end

  assign sample.ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= sample.valid;
      end
      for (int i = 2; i <= NumStages; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  logic signed [SampleW-1:0] raw [3];

  always_comb begin
    raw[0] = sample.raw_x;
    raw[1] = sample.raw_y;
    raw[2] = sample.raw_z;
  end

  // Stage 1: bias removal, exact in 17 bits, and the product of the two
  // Q2.14 factors, which is Q4.28 in 32 bits.
  logic signed [SampleW:0] diff [3];
  logic        [31:0]      gs   [3];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int a = 0; a < 3; a++) begin
        diff[a] <= {raw[a][SampleW-1], raw[a]} - {bias[a][SampleW-1], bias[a]};
        gs[a]   <= 32'(inv_gain[a]) * 32'(common_scale);
      end
    end
  end

  // Stage 2: the full scaled product, exact in 49 signed bits.
  logic signed [48:0] prod [3];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int a = 0; a < 3; a++) begin
        prod[a] <= diff[a] * $signed({1'b0, gs[a]});
      end
    end
  end

  // Stage 3: dropping the 28 fraction bits of a two's complement value is a
  // floor, so the corrected axis is simply the top 21 bits. Its magnitude
  // stays below 2^20, which bounds the square at 40 bits.
  logic signed [20:0]        corr     [3];
  logic        [19:0]        corr_abs [3];
  logic        [SampleW-1:0] corr_sat [3];
  logic        [2:0]         corr_ovf;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      corr[a]     = prod[a][48:28];
      corr_abs[a] = corr[a][20] ? 20'(-corr[a]) : corr[a][19:0];
      corr_ovf[a] = (corr[a][20:15] != {6{corr[a][15]}});
      if (corr_ovf[a]) begin
        corr_sat[a] = corr[a][20] ? 16'h8000 : 16'h7FFF;
      end else begin
        corr_sat[a] = corr[a][15:0];
      end
    end
  end

  logic [2:0][SampleW-1:0] cal3;
  logic                    ovf3;
  logic [39:0]             sq3 [3];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int a = 0; a < 3; a++) begin
        cal3[a] <= corr_sat[a];
        sq3[a]  <= 40'(corr_abs[a]) * 40'(corr_abs[a]);
      end
      ovf3 <= |corr_ovf;
    end
  end

  // Stage 4: field energy. Anything at or above 2^32 has a root beyond 16
  // bits, so only the low word goes on to the square root.
  logic [41:0] energy;

  assign energy = 42'(sq3[0]) + 42'(sq3[1]) + 42'(sq3[2]);

  root_stage_t st4;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      st4.cal     <= cal3;
      st4.ovf     <= ovf3;
      st4.big     <= |energy[41:32];
      st4.rt.rem  <= '0;
      st4.rt.root <= '0;
      st4.rt.rad  <= energy[31:0];
    end
  end

  // One step of the restoring square root: bring down the next two radicand
  // bits and try to subtract four times the root plus one.
  function automatic root_state_t root_step(root_state_t s);
    logic [17:0] rem_w;
    logic [17:0] trial;
    root_state_t r;
    rem_w = {s.rem[15:0], s.rad[31:30]};
    trial = {s.root, 2'b01};
    r.rad = {s.rad[29:0], 2'b00};
    if (rem_w >= trial) begin
      r.rem  = rem_w - trial;
      r.root = {s.root[14:0], 1'b1};
    end else begin
      r.rem  = rem_w;
      r.root = {s.root[14:0], 1'b0};
    end
    return r;
  endfunction

  // Stages 5 to 12: two root bits per stage; the last stage is the output
  // register.
  root_stage_t st_root [RootStages];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      st_root[0].cal <= st4.cal;
      st_root[0].ovf <= st4.ovf;
      st_root[0].big <= st4.big;
      st_root[0].rt  <= root_step(root_step(st4.rt));
    end
    for (int s = 1; s < RootStages; s++) begin
      if (en[5+s]) begin
        st_root[s].cal <= st_root[s-1].cal;
        st_root[s].ovf <= st_root[s-1].ovf;
        st_root[s].big <= st_root[s-1].big;
        st_root[s].rt  <= root_step(root_step(st_root[s-1].rt));
      end
    end
  end

  assign result.valid     = vld[NumStages];
  assign result.cal_x     = st_root[RootStages-1].cal[0];
  assign result.cal_y     = st_root[RootStages-1].cal[1];
  assign result.cal_z     = st_root[RootStages-1].cal[2];
  assign result.magnitude = st_root[RootStages-1].big ? '1 : st_root[RootStages-1].rt.root;
  assign result.overflow  = st_root[RootStages-1].ovf || st_root[RootStages-1].big;

  // The pipeline is empty in the cycle after reset.
  a_empty_after_reset: assert property (@(posedge clk) $past(rst) |-> vld == '0)
    else $error("pipeline holds an item straight after reset");

  // A full energy stage whose successor refuses it keeps its item.
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (vld[4] && !en[4]) |=> vld[4])
    else $error("stalled item lost in the energy stage");

  // The root remainder never exceeds twice the root.
  a_root_remainder: assert property (@(posedge clk) disable iff (rst)
    vld[NumStages] |->
      (st_root[RootStages-1].rt.rem <= {1'b0, st_root[RootStages-1].rt.root, 1'b0}))
    else $error("square root remainder out of bounds");

endmodule
